@@ rtl/core/imdu_pkg.sv @@
// Package for the integer multiply and divide unit: widths, command codes and state type.
package imdu_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int CMD_BITS  = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_MUL  = 3'd0,
    CMD_UDIV = 3'd1,
    CMD_UREM = 3'd2,
    CMD_SDIV = 3'd3,
    CMD_SREM = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_t;

endpackage

@@ rtl/core/int32_mul_div_unit.sv @@
// Bit-serial 32-bit multiply, divide and remainder unit.
//
// Input channel: in_valid / in_stall carry a command (multiply, unsigned or
// signed divide, unsigned or signed remainder) and two operand words. A word
// is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result word per input word.
// From acceptance to out_valid a word passes a load, 32 shift steps and a
// sign fix-up. One bit of product or quotient is produced per cycle in the
// shift steps, by an adder for multiply or a trial subtractor for divide;
// no new word is taken until the result is loaded into the output register.
// Divide or remainder by zero, and unused command codes, give a zero result.
// Signed commands work on magnitudes and negate at the end, so the most
// negative dividend divided by -1 wraps to itself.
// Reset (rst_n low, synchronous) empties the unit: no result pending, input
// ready. If the receiver stalls, the result is held in the output register;
// the unit still takes and computes the next word, then waits in fix-up
// until the output register is free.
module int32_mul_div_unit
  import imdu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_BITS-1:0]  in_command,
  input  logic [WORD_BITS-1:0] in_operand_a,
  input  logic [WORD_BITS-1:0] in_operand_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_result
);

  state_t state_r, state_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_result_r, out_result_nxt;

  // Datapath: num_r is dividend/quotient or multiplier, den_r is divisor or
  // multiplicand, acc_r is partial remainder or product.
  logic [WORD_BITS-1:0] num_r, num_nxt;
  logic [WORD_BITS-1:0] den_r, den_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic is_mul_r, want_rem_r, neg_q_r, neg_r_r, zero_r;
  logic is_mul_nxt, want_rem_nxt, neg_q_nxt, neg_r_nxt, zero_nxt;

  logic                 accept;
  logic                 load_out;
  logic                 cmd_ok, cmd_mul, cmd_sgn, cmd_rem;
  logic                 a_neg, b_neg;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] sel, fixed;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign load_out = (state_r == ST_FIX) && (!out_valid_r || !out_stall);

  // Command decode
  always_comb begin
    cmd_ok  = 1'b1;
    cmd_mul = 1'b0;
    cmd_sgn = 1'b0;
    cmd_rem = 1'b0;
    unique case (cmd_t'(in_command))
      CMD_MUL:  cmd_mul = 1'b1;
      CMD_UDIV: ;
      CMD_UREM: cmd_rem = 1'b1;
      CMD_SDIV: cmd_sgn = 1'b1;
      CMD_SREM: begin
        cmd_sgn = 1'b1;
        cmd_rem = 1'b1;
      end
      default:  cmd_ok = 1'b0;
    endcase
  end

  assign a_neg = cmd_sgn && in_operand_a[WORD_BITS-1];
  assign b_neg = cmd_sgn && in_operand_b[WORD_BITS-1];

  // Restoring divide step: 33-bit trial subtract
  assign shifted = {acc_r, num_r[WORD_BITS-1]};
  assign diff    = shifted - {1'b0, den_r};

  // Fix-up: select, negate, force zero
  always_comb begin
    if (is_mul_r) begin
      sel = acc_r;
    end else if (want_rem_r) begin
      sel = acc_r;
    end else begin
      sel = num_r;
    end
    if (zero_r) begin
      fixed = '0;
    end else if (!is_mul_r && ((want_rem_r && neg_r_r) || (!want_rem_r && neg_q_r))) begin
      fixed = '0 - sel;
    end else begin
      fixed = sel;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    acc_nxt        = acc_r;
    is_mul_nxt     = is_mul_r;
    want_rem_nxt   = want_rem_r;
    neg_q_nxt      = neg_q_r;
    neg_r_nxt      = neg_r_r;
    zero_nxt       = zero_r;
    out_result_nxt = out_result_r;
    out_valid_nxt  = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt    = ST_RUN;
          cnt_nxt      = CNT_BITS'(WORD_BITS - 1);
          num_nxt      = a_neg ? ('0 - in_operand_a) : in_operand_a;
          den_nxt      = b_neg ? ('0 - in_operand_b) : in_operand_b;
          acc_nxt      = '0;
          is_mul_nxt   = cmd_mul;
          want_rem_nxt = cmd_rem;
          neg_q_nxt    = a_neg ^ b_neg;
          neg_r_nxt    = a_neg;
          zero_nxt     = !cmd_ok || (!cmd_mul && (in_operand_b == '0));
        end
      end
      ST_RUN: begin
        if (is_mul_r) begin
          if (num_r[0]) begin
            acc_nxt = acc_r + den_r;
          end
          num_nxt = num_r >> 1;
          den_nxt = den_r << 1;
        end else begin
          // no borrow means the shifted remainder covers the divisor
          if (!diff[WORD_BITS]) begin
            acc_nxt = diff[WORD_BITS-1:0];
          end else begin
            acc_nxt = shifted[WORD_BITS-1:0];
          end
          num_nxt = {num_r[WORD_BITS-2:0], !diff[WORD_BITS]};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (load_out) begin
          out_result_nxt = fixed;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    acc_r        <= acc_nxt;
    is_mul_r     <= is_mul_nxt;
    want_rem_r   <= want_rem_nxt;
    neg_q_r      <= neg_q_nxt;
    neg_r_r      <= neg_r_nxt;
    zero_r       <= zero_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN))
    else $error("accepted word did not start the shift sequence");

  a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cnt_r != '0) |=> (state_r == ST_RUN))
    else $error("shift sequence left early");

  a_fix_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX) |-> ($past(state_r) == ST_RUN || $past(state_r) == ST_FIX))
    else $error("fix-up entered without a shift sequence");

  a_out_from_fix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIX))
    else $error("result appeared without fix-up");

endmodule
